// ----- hw/rtl/cfr_pkg.sv -----
// cfr_pkg: types and constants shared by the command frame receiver.
// No dependencies; compiled before the interface and all modules.
package cfr_pkg;

  localparam int REG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_FULL_CODE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BEACON_CODE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_READ_CODE   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WRITE_CODE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FULL_LEN    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BEACON_LEN  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_READ_LEN    = 3'd6;

  // Operation codes
  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  // Write-parameter frame: size byte is the third byte, frame is size plus 4
  localparam logic [8:0] SIZE_BYTE_COUNT = 9'd3;
  localparam logic [8:0] WRITE_OVERHEAD  = 9'd4;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
    logic [7:0] read_position;
  } cfr_in_t;

  typedef struct packed {
    logic       frame_done;
    logic       frame_dropped;
    logic [7:0] frame_length;
    logic [7:0] command;
    logic [7:0] write_payload_size;
    logic [7:0] read_data;
  } cfr_out_t;

endpackage

// ----- hw/rtl/cfr_stream_if.sv -----
// cfr_stream_if: valid/ready channel carrying one payload per transaction.
// Payload type is set per instance; uses no package items directly.
interface cfr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/cfr_ram.sv -----
// cfr_ram: generic single-clock RAM, one write and one read port,
// registered read data held while no read is issued. No dependencies.
module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- hw/rtl/command_frame_receiver.sv -----
// Command frame receiver with configurable command codes and frame lengths. Every
// transaction on req is one receive or read, and each gives one result transaction on rsp.
// Results pass the registered read of the frame store RAM and then the output
// register. One transaction per cycle is sustained while rsp is ready. Received bytes
// go into the store at the current position. A frame completes when its command's length is
// reached; write-parameter frames complete at payload size plus 4. Reaching the store depth
// without completion drops the frame (frame_dropped). Entries never written since reset read
// as zero. One valid flag per entry tracks this, so no clearing pass is needed.
// Uses cfr_pkg, cfr_stream_if and cfr_ram.
module command_frame_receiver #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [cfr_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [7:0]                      wr_data,
  cfr_stream_if.sink                      req,
  cfr_stream_if.source                    rsp
);
  import cfr_pkg::*;

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam logic [8:0] DEPTH9 = 9'(BUFFER_DEPTH);

  // configuration
  logic [7:0] full_code, beacon_code, read_code, write_code;
  logic [7:0] full_len, beacon_len, read_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_code   <= 8'd0;
      beacon_code <= 8'd1;
      read_code   <= 8'd2;
      write_code  <= 8'd3;
      full_len    <= 8'd2;
      beacon_len  <= 8'd2;
      read_len    <= 8'd3;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FULL_CODE:   full_code   <= wr_data;
        REG_BEACON_CODE: beacon_code <= wr_data;
        REG_READ_CODE:   read_code   <= wr_data;
        REG_WRITE_CODE:  write_code  <= wr_data;
        REG_FULL_LEN:    full_len    <= wr_data;
        REG_BEACON_LEN:  beacon_len  <= wr_data;
        REG_READ_LEN:    read_len    <= wr_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid, out_valid, s1_adv, accept;
  cfr_in_t  in_item;
  cfr_out_t out_item;

  assign in_item    = req.payload;
  assign s1_adv     = s1_valid && (!out_valid || rsp.ready);
  assign req.ready  = !s1_valid || s1_adv;
  assign accept     = req.valid && req.ready;
  assign rsp.valid  = out_valid;
  assign rsp.payload = out_item;

  // frame state
  logic [7:0] write_position, write_position_next;
  logic [7:0] current_command, current_command_next;
  logic [7:0] payload_size, payload_size_next;
  logic [7:0] last_length, last_length_next;
  logic [BUFFER_DEPTH-1:0] written;

  logic [7:0] pos;
  logic [8:0] count;
  logic       complete, dropped, rx;

  assign rx    = accept && (in_item.operation == OP_RECEIVE);
  assign pos   = (write_position >= 8'(BUFFER_DEPTH)) ? 8'd0 : write_position;
  assign count = {1'b0, pos} + 9'd1;

  always_comb begin
    current_command_next = current_command;
    payload_size_next    = payload_size;
    last_length_next     = last_length;
    write_position_next  = count[7:0];
    complete             = 1'b0;
    dropped              = 1'b0;
    if (pos == 8'd0) begin
      current_command_next = in_item.rx_byte;
    end else begin
      if (current_command == full_code) begin
        complete = count >= {1'b0, full_len};
      end else if (current_command == beacon_code) begin
        complete = count >= {1'b0, beacon_len};
      end else if (current_command == read_code) begin
        complete = count >= {1'b0, read_len};
      end else if (current_command == write_code) begin
        if (count == SIZE_BYTE_COUNT) begin
          payload_size_next = in_item.rx_byte;
        end else if (count == {1'b0, payload_size} + WRITE_OVERHEAD) begin
          complete = 1'b1;
        end
      end
      if (complete) begin
        last_length_next    = count[7:0];
        write_position_next = 8'd0;
      end else if (count >= DEPTH9) begin
        write_position_next = 8'd0;
        dropped             = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position  <= 8'd0;
      current_command <= 8'd0;
      payload_size    <= 8'd0;
      last_length     <= 8'd0;
      written         <= '0;
    end else if (rx) begin
      write_position  <= write_position_next;
      current_command <= current_command_next;
      payload_size    <= payload_size_next;
      last_length     <= last_length_next;
      written[pos[ADDR_W-1:0]] <= 1'b1;
    end
  end

  // frame store; read and write never issue in the same cycle, one transaction per cycle while rsp is ready
  logic             rd_issue, rd_in_range;
  logic [7:0]       ram_q;

  assign rd_issue    = accept && (in_item.operation == OP_READ);
  assign rd_in_range = in_item.read_position < 8'(BUFFER_DEPTH);

  cfr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (rx),
    .waddr (pos[ADDR_W-1:0]),
    .wdata (in_item.rx_byte),
    .re    (rd_issue),
    .raddr (in_item.read_position[ADDR_W-1:0]),
    .rdata (ram_q)
  );

  // stage 1: result fields wait for the RAM read
  cfr_out_t s1_item;
  cfr_out_t s1_result;
  logic     s1_use_ram;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_use_ram <= rd_issue && rd_in_range &&
                    written[in_item.read_position[ADDR_W-1:0]];
      s1_item.frame_done         <= rx && complete && (pos != 8'd0);
      s1_item.frame_dropped      <= rx && dropped;
      s1_item.frame_length       <= rx ? last_length_next : last_length;
      s1_item.command            <= rx ? current_command_next : current_command;
      s1_item.write_payload_size <= rx ? payload_size_next : payload_size;
      s1_item.read_data          <= 8'd0;
    end
  end

  always_comb begin
    s1_result           = s1_item;
    s1_result.read_data = s1_use_ram ? ram_q : 8'd0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item <= s1_result;
    end
  end

endmodule

// ----- sim/command_frame_receiver_tb.sv -----
// Self-checking testbench for command_frame_receiver: drives receive and read transactions,
// predicts every result in a scoreboard class and checks the responses field by field.
// Depends on cfr_pkg, cfr_stream_if and the command_frame_receiver RTL.
`timescale 1ns / 1ps

module command_frame_receiver_tb;
  import cfr_pkg::*;

  localparam int BUFFER_DEPTH = 128;
  localparam int NUM_REGS = 7;
  localparam logic [REG_IDX_W-1:0] UNUSED_REG_IDX = 3'd7;
  localparam int LONG_HOLD = 300;
  localparam int QUIET_LIMIT = 3000;

  // Predicts the frame receiver transaction by transaction and holds the responses still due.
  class frame_scoreboard;
    logic [7:0] regs [NUM_REGS];
    logic [7:0] store [BUFFER_DEPTH];
    int unsigned wpos;
    logic [7:0] cur_cmd;
    logic [7:0] psize;
    logic [7:0] last_len;
    cfr_out_t expected_q [$];
    int unsigned errors;

    function new();
      regs[REG_FULL_CODE] = 8'd0;
      regs[REG_BEACON_CODE] = 8'd1;
      regs[REG_READ_CODE] = 8'd2;
      regs[REG_WRITE_CODE] = 8'd3;
      regs[REG_FULL_LEN] = 8'd2;
      regs[REG_BEACON_LEN] = 8'd2;
      regs[REG_READ_LEN] = 8'd3;
      foreach (store[i]) store[i] = 8'h00;
      wpos = 0;
      cur_cmd = 8'h00;
      psize = 8'h00;
      last_len = 8'h00;
      errors = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [7:0] val);
      if (idx <= REG_READ_LEN) regs[idx] = val;
    endfunction

    function void note_input(cfr_in_t it);
      cfr_out_t ex;
      int unsigned pos;
      int unsigned cnt;
      bit complete;
      ex = '0;
      if (it.operation == OP_READ) begin
        if (it.read_position < BUFFER_DEPTH) ex.read_data = store[it.read_position];
      end else begin
        pos = (wpos >= BUFFER_DEPTH) ? 0 : wpos;
        store[pos] = it.rx_byte;
        cnt = pos + 1;
        wpos = cnt;
        if (pos == 0) begin
          cur_cmd = it.rx_byte;
        end else begin
          complete = 1'b0;
          // priority order: full, beacon, read parameter, write parameter
          if (cur_cmd == regs[REG_FULL_CODE]) begin
            complete = cnt >= regs[REG_FULL_LEN];
          end else if (cur_cmd == regs[REG_BEACON_CODE]) begin
            complete = cnt >= regs[REG_BEACON_LEN];
          end else if (cur_cmd == regs[REG_READ_CODE]) begin
            complete = cnt >= regs[REG_READ_LEN];
          end else if (cur_cmd == regs[REG_WRITE_CODE]) begin
            if (cnt == SIZE_BYTE_COUNT) psize = it.rx_byte;
            else if (cnt == psize + WRITE_OVERHEAD) complete = 1'b1;
          end
          if (complete) begin
            last_len = cnt[7:0];
            wpos = 0;
            ex.frame_done = 1'b1;
          end
          if (wpos >= BUFFER_DEPTH) begin
            wpos = 0;
            ex.frame_dropped = 1'b1;
          end
        end
      end
      ex.frame_length = last_len;
      ex.command = cur_cmd;
      ex.write_payload_size = psize;
      expected_q.push_back(ex);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task check_result(cfr_out_t got);
      cfr_out_t ex;
      if (expected_q.size() == 0) begin
        report($sformatf("response with nothing outstanding: %h", got));
      end else begin
        ex = expected_q.pop_front();
        if (got.frame_done !== ex.frame_done)
          report($sformatf("frame_done %b, want %b", got.frame_done, ex.frame_done));
        if (got.frame_dropped !== ex.frame_dropped)
          report($sformatf("frame_dropped %b, want %b", got.frame_dropped, ex.frame_dropped));
        if (got.frame_length !== ex.frame_length)
          report($sformatf("frame_length %h, want %h", got.frame_length, ex.frame_length));
        if (got.command !== ex.command)
          report($sformatf("command %h, want %h", got.command, ex.command));
        if (got.write_payload_size !== ex.write_payload_size)
          report($sformatf("write_payload_size %h, want %h",
                           got.write_payload_size, ex.write_payload_size));
        if (got.read_data !== ex.read_data)
          report($sformatf("read_data %h, want %h", got.read_data, ex.read_data));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic wr_en;
  logic [REG_IDX_W-1:0] wr_index;
  logic [7:0] wr_data;

  cfr_stream_if #(.payload_t(cfr_in_t))  req_if ();
  cfr_stream_if #(.payload_t(cfr_out_t)) rsp_if ();

  command_frame_receiver #(.BUFFER_DEPTH(BUFFER_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req      (req_if),
    .rsp      (rsp_if)
  );

  frame_scoreboard sb;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  bit busy_mode;
  bit long_hold;
  bit moved;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Receiver side: random back-pressure, plus one long hold-off on request.
  initial begin
    rsp_if.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        rsp_if.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        rsp_if.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready = 1'b1;
        if (busy_mode && $urandom_range(0, 9) < 3) stall_left = idle_len();
      end
    end
  end

  // Transaction monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (req_if.valid && req_if.ready) begin
        sb.note_input(req_if.payload);
        moved = 1'b1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_result(rsp_if.payload);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("command_frame_receiver_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic cfr_in_t rx_item(logic [7:0] b);
    cfr_in_t it;
    it.operation = OP_RECEIVE;
    it.rx_byte = b;
    it.read_position = 8'($urandom_range(0, 254));
    return it;
  endfunction

  function automatic cfr_in_t read_item(logic [7:0] p);
    cfr_in_t it;
    it.operation = OP_READ;
    it.rx_byte = 8'($urandom_range(0, 255));
    it.read_position = p;
    return it;
  endfunction

  function automatic logic [7:0] pick_pos();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 254));
  endfunction

  // Called at a falling edge; returns at a falling edge after acceptance and any idle gap.
  task automatic push(cfr_in_t it);
    req_if.payload = it;
    req_if.valid = 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    if (busy_mode && $urandom_range(0, 9) < 3) begin
      req_if.valid = 1'b0;
      repeat (idle_len()) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [7:0] val);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(negedge clk);
    wr_en = 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic configure(logic [7:0] fc, logic [7:0] bc, logic [7:0] rc, logic [7:0] wc,
                           logic [7:0] fl, logic [7:0] bl, logic [7:0] rl);
    wait_drained();
    reg_write(REG_FULL_CODE, fc);
    reg_write(REG_BEACON_CODE, bc);
    reg_write(REG_READ_CODE, rc);
    reg_write(REG_WRITE_CODE, wc);
    reg_write(REG_FULL_LEN, fl);
    reg_write(REG_BEACON_LEN, bl);
    reg_write(REG_READ_LEN, rl);
  endtask

  task automatic send_bytes(logic [7:0] cmd, int unsigned n);
    push(rx_item(cmd));
    repeat (n - 1) begin
      if ($urandom_range(0, 99) < 6) push(read_item(pick_pos()));
      push(rx_item(8'($urandom_range(0, 255))));
    end
  endtask

  task automatic fixed_frame(logic [7:0] cmd, logic [7:0] len);
    int unsigned n;
    n = (len < 2) ? 2 : len;
    if (n > BUFFER_DEPTH) n = BUFFER_DEPTH;
    send_bytes(cmd, n);
  endtask

  task automatic write_frame(logic [7:0] cmd, logic [7:0] size);
    int unsigned n;
    n = size + 4;
    if (n > BUFFER_DEPTH) n = BUFFER_DEPTH;
    push(rx_item(cmd));
    push(rx_item(8'($urandom_range(0, 255))));
    push(rx_item(size));
    repeat (n - 3) begin
      if ($urandom_range(0, 99) < 6) push(read_item(pick_pos()));
      push(rx_item(8'($urandom_range(0, 255))));
    end
  endtask

  task automatic random_frame();
    int unsigned kind;
    int unsigned r;
    logic [7:0] size;
    kind = $urandom_range(0, 99);
    if (kind < 18) begin
      fixed_frame(sb.regs[REG_FULL_CODE], sb.regs[REG_FULL_LEN]);
    end else if (kind < 34) begin
      fixed_frame(sb.regs[REG_BEACON_CODE], sb.regs[REG_BEACON_LEN]);
    end else if (kind < 50) begin
      fixed_frame(sb.regs[REG_READ_CODE], sb.regs[REG_READ_LEN]);
    end else if (kind < 78) begin
      r = $urandom_range(0, 99);
      if (r < 80) size = 8'($urandom_range(0, 12));
      else if (r < 93) size = 8'($urandom_range(13, 124));
      else size = 8'($urandom_range(125, 255));  // runs past the store depth
      write_frame(sb.regs[REG_WRITE_CODE], size);
    end else if (kind < 82) begin
      // random command byte; an unknown one collects until the store fills
      send_bytes(8'($urandom_range(0, 255)), BUFFER_DEPTH);
    end else if (kind < 88) begin
      // broken frame: a few stray bytes
      send_bytes(8'($urandom_range(0, 255)), $urandom_range(1, 3));
    end else begin
      repeat ($urandom_range(1, 4)) push(read_item(pick_pos()));
    end
  endtask

  task automatic run_phase(int unsigned quota);
    int unsigned target;
    target = items_sent + quota;
    while (items_sent < target) begin
      busy_mode = ($urandom_range(0, 3) != 0);
      random_frame();
    end
  endtask

  function automatic logic [7:0] rand_len();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(1, 10));
  endfunction

  initial begin
    sb = new();
    items_sent = 0;
    busy_mode = 1'b1;
    long_hold = 1'b0;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = 8'h00;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: untouched entries, out-of-range reads, a frame of each command (two write frames)
    push(read_item(8'd0));
    push(read_item(8'd127));
    push(read_item(8'd128));
    push(read_item(8'd254));
    push(rx_item(8'h00));
    push(rx_item(8'hFF));
    push(rx_item(8'h01));
    push(rx_item(8'hAA));
    push(rx_item(8'h02));
    push(rx_item(8'h55));
    push(rx_item(8'h80));
    push(rx_item(8'h03));
    push(rx_item(8'h11));
    push(rx_item(8'h02));
    push(rx_item(8'h22));
    push(rx_item(8'h33));
    push(rx_item(8'h44));
    push(rx_item(8'h03));
    push(rx_item(8'hEE));
    push(rx_item(8'h00));
    push(rx_item(8'h77));
    push(read_item(8'd2));
    push(read_item(8'd1));

    // Reset settings; receiver holds off while the sender keeps offering
    long_hold = 1'b1;
    run_phase(200);

    configure(8'($urandom_range(0, 63)), 8'($urandom_range(64, 127)),
              8'($urandom_range(128, 191)), 8'($urandom_range(192, 255)),
              8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)));
    run_phase(100);
    wait_drained();
    run_phase(100);

    // Extremes: never completes, completes exactly at depth, zero length
    configure(8'hFF, 8'h00, 8'h80, 8'h7F, 8'd255, 8'd128, 8'd0);
    run_phase(250);

    // Shared codes: full beats beacon, read beats write
    configure(8'h10, 8'h10, 8'h20, 8'h20, 8'd1, 8'd6, 8'd5);
    run_phase(150);

    configure(8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'd1, 8'd4, 8'd6);
    reg_write(UNUSED_REG_IDX, 8'hA5);
    run_phase(100);

    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              rand_len(), rand_len(), rand_len());
    run_phase(150);

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d responses never arrived", sb.expected_q.size()));
    if (sb.errors == 0) begin
      $display("command_frame_receiver_tb: PASS");
    end else begin
      $display("command_frame_receiver_tb: FAIL");
    end
    $finish;
  end

endmodule
